>>> rtl/core/tlge_pkg.sv
// Shared types and constants for the toroidal life generation engine.
// No dependencies.
package tlge_pkg;
	localparam int DefMaxWidth  = 64;
	localparam int DefMaxHeight = 64;
	localparam int SizeW = 7;
	localparam int CoordW = 6;
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_GEN   = 2'd2;
	localparam logic [1:0] KIND_NOP   = 2'd3;
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;
endpackage

>>> rtl/core/toroidal_life_generation_engine.sv
// Toroidal life engine: command path, generation sequencer and grid memories.
// Depends on tlge_pkg.
// A cell read or write steps through ST_ACC and ST_RD, and done follows ST_RD.
// A generation evaluates each active cell in ST_NB and ST_DEC, then commits each in ST_CPR and ST_CPW.
// The per-cell cost is set by the single read port of the alive memory: nine reads
// (eight neighbors and the cell, which also brings its obstacle bit), the registered
// read data and one writeback; the commit pass reads and copies each cell. Reset clears
// the alive and obstacle memories, one per cycle (4096 at the default size); busy is high
// meanwhile. Results cannot be stalled; done pulses for one cycle with the result word.
module toroidal_life_generation_engine
	import tlge_pkg::*;
#(
	parameter int MAX_WIDTH  = DefMaxWidth,
	parameter int MAX_HEIGHT = DefMaxHeight
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        kind,
	input  logic [CoordW-1:0] cell_x,
	input  logic [CoordW-1:0] cell_y,
	input  logic              alive_in,
	input  logic              obstacle_in,
	output logic              done,
	output logic              cell_alive,
	output logic              cell_obstacle,
	output logic              out_of_range,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_index,
	input  logic [SizeW-1:0]  cfg_data
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int CELLS = 1 << AW;

	localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_ACC = 4'd2, ST_RD = 4'd3,
		ST_NB = 4'd4, ST_DEC = 4'd5, ST_CPR = 4'd6, ST_CPW = 4'd7, ST_FIN = 4'd8;

	logic [3:0] st_q;
	logic [SizeW-1:0] wreg_q, hreg_q;
	logic [XW-1:0] w1_q, sx_q; // w1 = active width minus one
	logic [YW-1:0] h1_q, sy_q;
	logic [3:0] nb_q;           // neighbor read index 0..8, and 9 for the last data
	logic [3:0] cnt_q;
	logic self_q, obs_q, pend_q;
	logic [AW-1:0] clr_q;
	logic [1:0] kind_q;
	logic [XW-1:0] cx_q;
	logic [YW-1:0] cy_q;
	logic a_q, o_q, oor_q;

	// Grid memories: one read and one write port each.
	logic alive_mem [CELLS];
	logic obs_mem [CELLS];
	logic next_mem [CELLS];
	logic [AW-1:0] ra, wa, na;
	logic we_a, we_o, we_n, wd_a, wd_o, wd_n, rd_a, rd_o, rd_n;

	always_ff @(posedge clk) begin
		if (we_a) alive_mem[wa] <= wd_a;
		if (we_o) obs_mem[wa] <= wd_o;
		if (we_n) next_mem[wa] <= wd_n;
		rd_a <= alive_mem[ra];
		rd_o <= obs_mem[ra];
		rd_n <= next_mem[na];
	end

	function automatic logic [AW-1:0] addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
		addr = {y, x};
	endfunction

	// Active size, saturated to 1..MAX.
	logic [XW-1:0] w1_c;
	logic [YW-1:0] h1_c;
	always_comb begin
		if (wreg_q == '0) w1_c = '0;
		else if (32'(wreg_q) > MAX_WIDTH) w1_c = XW'(MAX_WIDTH - 1);
		else w1_c = XW'(wreg_q - 1'b1);
		if (hreg_q == '0) h1_c = '0;
		else if (32'(hreg_q) > MAX_HEIGHT) h1_c = YW'(MAX_HEIGHT - 1);
		else h1_c = YW'(hreg_q - 1'b1);
	end

	// Neighbor coordinates with wrap at active size.
	logic [XW-1:0] nx;
	logic [YW-1:0] ny;
	logic [1:0] dx, dy;
	always_comb begin
		unique case (nb_q)
			4'd0, 4'd3, 4'd6: dx = 2'd0;
			4'd1, 4'd4, 4'd7: dx = 2'd1;
			default: dx = 2'd2;
		endcase
		dy = (nb_q < 4'd3) ? 2'd0 : ((nb_q < 4'd6) ? 2'd1 : 2'd2);
		unique case (dx)
			2'd0: nx = (sx_q == '0) ? w1_q : sx_q - 1'b1;
			2'd2: nx = (sx_q == w1_q) ? '0 : sx_q + 1'b1;
			default: nx = sx_q;
		endcase
		unique case (dy)
			2'd0: ny = (sy_q == '0) ? h1_q : sy_q - 1'b1;
			2'd2: ny = (sy_q == h1_q) ? '0 : sy_q + 1'b1;
			default: ny = sy_q;
		endcase
	end

	logic cmd_oor;
	assign cmd_oor = (32'(cx_q) > 32'(w1_c)) || (32'(cy_q) > 32'(h1_c));

	always_comb begin
		ra = addr(cx_q, cy_q);
		na = addr(sx_q, sy_q);
		wa = addr(cx_q, cy_q);
		we_a = 1'b0; we_o = 1'b0; we_n = 1'b0;
		wd_a = 1'b0; wd_o = 1'b0; wd_n = 1'b0;
		unique case (st_q)
			ST_CLR: begin
				wa = clr_q; we_a = 1'b1; we_o = 1'b1;
			end
			ST_ACC: begin
				if (kind_q == KIND_WRITE && !cmd_oor) begin
					we_a = 1'b1; we_o = 1'b1; wd_a = a_q; wd_o = o_q;
				end
			end
			ST_NB: ra = addr(nx, ny);
			ST_DEC: begin
				wa = addr(sx_q, sy_q); we_n = 1'b1;
				if (obs_q) wd_n = self_q;
				else wd_n = (cnt_q == 4'd3) || (self_q && cnt_q == 4'd2);
			end
			ST_CPW: begin
				wa = addr(sx_q, sy_q); we_a = 1'b1; wd_a = rd_n;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q <= kind; cx_q <= XW'(cell_x); cy_q <= YW'(cell_y);
			a_q <= alive_in; o_q <= obstacle_in;
			oor_q <= (32'(cell_x) >= MAX_WIDTH) || (32'(cell_y) >= MAX_HEIGHT);
		end
	end

	logic oor_all;
	assign oor_all = oor_q || cmd_oor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; clr_q <= '0;
			wreg_q <= SizeW'(64); hreg_q <= SizeW'(64);
			w1_q <= '0; h1_q <= '0; sx_q <= '0; sy_q <= '0;
			nb_q <= '0; cnt_q <= '0; self_q <= 1'b0; obs_q <= 1'b0; pend_q <= 1'b0;
			done <= 1'b0; cell_alive <= 1'b0; cell_obstacle <= 1'b0; out_of_range <= 1'b0;
		end else begin
			done <= (st_q == ST_RD) || (st_q == ST_FIN);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WIDTH) wreg_q <= cfg_data;
				else hreg_q <= cfg_data;
			end
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == CELLS - 1) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						if (kind == KIND_GEN) begin
							w1_q <= w1_c; h1_q <= h1_c; sx_q <= '0; sy_q <= '0;
							nb_q <= '0; cnt_q <= '0; pend_q <= 1'b0; st_q <= ST_NB;
						end else st_q <= ST_ACC;
					end
				end
				ST_ACC: st_q <= ST_RD;
				ST_RD: begin
					if (kind_q == KIND_GEN || kind_q == KIND_NOP || oor_all) begin
						cell_alive <= 1'b0; cell_obstacle <= 1'b0;
						out_of_range <= (kind_q != KIND_GEN && kind_q != KIND_NOP) && oor_all;
					end else if (kind_q == KIND_WRITE) begin
						// The read beside the write returned the old contents, so the written values are reported.
						cell_alive <= a_q; cell_obstacle <= o_q; out_of_range <= 1'b0;
					end else begin
						cell_alive <= rd_a; cell_obstacle <= rd_o; out_of_range <= 1'b0;
					end
					st_q <= ST_IDLE;
				end
				ST_NB: begin
					// Data for read nb_q-1 arrives now.
					if (pend_q) begin
						if (nb_q == 4'd5) begin self_q <= rd_a; obs_q <= rd_o; end
						else cnt_q <= cnt_q + {3'd0, rd_a};
					end
					pend_q <= 1'b1;
					if (nb_q == 4'd9) st_q <= ST_DEC;
					else nb_q <= nb_q + 1'b1;
				end
				ST_DEC: begin
					nb_q <= '0; cnt_q <= '0; pend_q <= 1'b0;
					if (sx_q == w1_q) begin
						sx_q <= '0;
						if (sy_q == h1_q) begin sy_q <= '0; st_q <= ST_CPR; end
						else begin sy_q <= sy_q + 1'b1; st_q <= ST_NB; end
					end else begin
						sx_q <= sx_q + 1'b1; st_q <= ST_NB;
					end
				end
				ST_CPR: st_q <= ST_CPW;
				ST_CPW: begin
					if (sx_q == w1_q) begin
						sx_q <= '0;
						if (sy_q == h1_q) begin sy_q <= '0; st_q <= ST_FIN; end
						else begin sy_q <= sy_q + 1'b1; st_q <= ST_CPR; end
					end else begin
						sx_q <= sx_q + 1'b1; st_q <= ST_CPR;
					end
				end
				ST_FIN: begin
					cell_alive <= 1'b0; cell_obstacle <= 1'b0;
					out_of_range <= 1'b0; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
endmodule

>>> rtl/core/tlge_checker.sv
// Port-level checks for the toroidal life generation engine.
// Depends on tlge_pkg; bound to the top level.
module tlge_checker
	import tlge_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cell_alive,
	input logic cell_obstacle,
	input logic out_of_range
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_oor_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> !cell_alive && !cell_obstacle)
		else $error("out of range result carries cell data");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while still busy");
endmodule

bind toroidal_life_generation_engine tlge_checker u_tlge_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.cell_alive(cell_alive), .cell_obstacle(cell_obstacle), .out_of_range(out_of_range)
);

>>> sim/tb_top.sv
// Self-checking testbench for the toroidal life generation engine.
// Depends on tlge_pkg and toroidal_life_generation_engine; holds its own grid predictor.
module tb_top;
	import tlge_pkg::*;

	localparam int GridCells = DefMaxWidth * DefMaxHeight;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        kind;
	logic [CoordW-1:0] cell_x;
	logic [CoordW-1:0] cell_y;
	logic              alive_in;
	logic              obstacle_in;
	logic              done;
	logic              cell_alive;
	logic              cell_obstacle;
	logic              out_of_range;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [0:0]        cfg_index;
	logic [SizeW-1:0]  cfg_data;

	// One result word as the engine reports it.
	typedef struct packed {
		logic alive;
		logic obstacle;
		logic oor;
	} cell_word_t;

	// Results still owed by the engine, oldest first.
	cell_word_t pending_words[$];

	// Our own copy of the grid and of the size registers.
	bit               life_alive[GridCells];
	bit               life_obstacle[GridCells];
	bit               life_next[GridCells];
	logic [SizeW-1:0] width_reg;
	logic [SizeW-1:0] height_reg;
	int unsigned      mismatches;

	toroidal_life_generation_engine i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.cell_x(cell_x), .cell_y(cell_y), .alive_in(alive_in), .obstacle_in(obstacle_in),
		.done(done), .cell_alive(cell_alive), .cell_obstacle(cell_obstacle),
		.out_of_range(out_of_range), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The limit leaves room for a handful of full-size generations plus everything else.
	initial begin
		#50000000;
		$display("FAIL");
		$finish;
	end

	// A size register of zero behaves as one, anything beyond the grid as the grid.
	function automatic int unsigned active_cols();
		if (width_reg == 0) return 1;
		if (width_reg > DefMaxWidth) return DefMaxWidth;
		return width_reg;
	endfunction

	function automatic int unsigned active_rows();
		if (height_reg == 0) return 1;
		if (height_reg > DefMaxHeight) return DefMaxHeight;
		return height_reg;
	endfunction

	// B3/S23 over the active window with wraparound. With a width or height
	// of one or two the wrapped neighbor positions repeat, and each of the
	// eight is counted as it lands, the cell itself included. Everything is
	// computed from the old grid before any cell is committed.
	function automatic void advance_generation();
		int unsigned w, h, n, i, nx, ny;
		w = active_cols();
		h = active_rows();
		for (int unsigned y = 0; y < h; y++) begin
			for (int unsigned x = 0; x < w; x++) begin
				i = y * DefMaxWidth + x;
				if (life_obstacle[i]) begin
					life_next[i] = life_alive[i];
				end else begin
					n = 0;
					for (int unsigned dx = 0; dx < 3; dx++) begin
						for (int unsigned dy = 0; dy < 3; dy++) begin
							if (dx == 1 && dy == 1) continue;
							nx = (x + w + dx - 1) % w;
							ny = (y + h + dy - 1) % h;
							n += life_alive[ny * DefMaxWidth + nx];
						end
					end
					life_next[i] = life_alive[i] ? (n == 2 || n == 3) : (n == 3);
				end
			end
		end
		for (int unsigned y = 0; y < h; y++) begin
			for (int unsigned x = 0; x < w; x++) begin
				life_alive[y * DefMaxWidth + x] = life_next[y * DefMaxWidth + x];
			end
		end
	endfunction

	// Applies one accepted command word to the grid copy and returns the
	// result the engine must report for it. Generation steps and the unused
	// kind report all zero; accesses outside the active window only flag.
	function automatic cell_word_t apply_command(logic [1:0] k, logic [CoordW-1:0] x,
			logic [CoordW-1:0] y, logic a, logic o);
		cell_word_t word;
		int unsigned i;
		word = '0;
		if (k == KIND_GEN) begin
			advance_generation();
		end else if (k == KIND_WRITE || k == KIND_READ) begin
			if (x >= active_cols() || y >= active_rows()) begin
				word.oor = 1'b1;
			end else begin
				i = y * DefMaxWidth + x;
				if (k == KIND_WRITE) begin
					life_alive[i] = a;
					life_obstacle[i] = o;
				end
				word.alive = life_alive[i];
				word.obstacle = life_obstacle[i];
			end
		end
		return word;
	endfunction

	function automatic void report_mismatch(string what, cell_word_t want, cell_word_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s expected a=%0b o=%0b oor=%0b got a=%0b o=%0b oor=%0b",
				$realtime, what, want.alive, want.obstacle, want.oor,
				got.alive, got.obstacle, got.oor);
	endfunction

	// Results cannot be held off, so every done cycle is checked against the
	// oldest outstanding prediction, field by field.
	always @(posedge clk) begin
		cell_word_t got, want;
		if (arst_n && done) begin
			got = '{alive: cell_alive, obstacle: cell_obstacle, oor: out_of_range};
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word", '0, got);
			end else begin
				want = pending_words.pop_front();
				if (got.alive !== want.alive) report_mismatch("cell_alive", want, got);
				if (got.obstacle !== want.obstacle) report_mismatch("cell_obstacle", want, got);
				if (got.oor !== want.oor) report_mismatch("out_of_range", want, got);
			end
		end
	end

	// Sends one command word after a random gap, which may be empty. With no
	// gap, start simply stays high for the next word.
	task automatic send_command(logic [1:0] k, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
			logic a, logic o);
		int unsigned gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		kind = k;
		cell_x = x;
		cell_y = y;
		alive_in = a;
		obstacle_in = o;
		do @(posedge clk); while (busy);
		pending_words.push_back(apply_command(k, x, y, a, o));
	endtask

	// Stops sending and waits until every owed result has come back.
	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Size registers are only touched while the engine is idle.
	task automatic write_size(logic [0:0] idx, logic [SizeW-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_WIDTH) width_reg = value;
		else height_reg = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Three corners of the full grid, both flag bits, and the unused kind.
	task automatic test_cell_access();
		send_command(KIND_READ, 6'd0, 6'd0, 1'b0, 1'b0);
		send_command(KIND_READ, 6'd63, 6'd63, 1'b0, 1'b0);
		send_command(KIND_WRITE, 6'd63, 6'd63, 1'b1, 1'b1);
		send_command(KIND_WRITE, 6'd0, 6'd0, 1'b1, 1'b0);
		send_command(KIND_WRITE, 6'd63, 6'd0, 1'b0, 1'b1);
		send_command(KIND_NOP, 6'd63, 6'd63, 1'b1, 1'b1);
		send_command(KIND_READ, 6'd63, 6'd63, 1'b0, 1'b0);
		send_command(KIND_READ, 6'd63, 6'd0, 1'b0, 1'b0);
	endtask

	// Degenerate sizes: zero acts as one and oversize clamps to the grid;
	// tiny tori make neighbors repeat and include the cell itself.
	task automatic test_size_extremes();
		write_size(CFG_WIDTH, 7'd0);
		write_size(CFG_HEIGHT, 7'd127);
		send_command(KIND_READ, 6'd1, 6'd0, 1'b0, 1'b0);
		send_command(KIND_WRITE, 6'd0, 6'd1, 1'b1, 1'b0);
		send_command(KIND_WRITE, 6'd0, 6'd2, 1'b1, 1'b0);
		send_command(KIND_GEN, 6'd0, 6'd0, 1'b0, 1'b0);
		send_command(KIND_READ, 6'd0, 6'd63, 1'b0, 1'b0);
		send_command(KIND_READ, 6'd0, 6'd1, 1'b0, 1'b0);
		write_size(CFG_WIDTH, 7'd2);
		write_size(CFG_HEIGHT, 7'd2);
		send_command(KIND_WRITE, 6'd1, 6'd1, 1'b1, 1'b0);
		send_command(KIND_GEN, 6'd0, 6'd0, 1'b0, 1'b0);
		send_command(KIND_READ, 6'd1, 6'd1, 1'b0, 1'b0);
		send_command(KIND_WRITE, 6'd2, 6'd0, 1'b1, 1'b1);
	endtask

	// A glider straddling the wrap corner of the full grid, next to an
	// obstacle, carried through two generations.
	task automatic test_glider_full_size();
		write_size(CFG_WIDTH, 7'd64);
		write_size(CFG_HEIGHT, 7'd64);
		send_command(KIND_WRITE, 6'd0, 6'd63, 1'b1, 1'b0);
		send_command(KIND_WRITE, 6'd1, 6'd0, 1'b1, 1'b0);
		send_command(KIND_WRITE, 6'd63, 6'd1, 1'b1, 1'b0);
		send_command(KIND_WRITE, 6'd0, 6'd1, 1'b1, 1'b0);
		send_command(KIND_WRITE, 6'd1, 6'd1, 1'b1, 1'b0);
		send_command(KIND_WRITE, 6'd2, 6'd2, 1'b0, 1'b1);
		send_command(KIND_GEN, 6'd0, 6'd0, 1'b0, 1'b0);
		send_command(KIND_GEN, 6'd0, 6'd0, 1'b0, 1'b0);
		send_command(KIND_READ, 6'd1, 6'd1, 1'b0, 1'b0);
		send_command(KIND_READ, 6'd2, 6'd2, 1'b0, 1'b0);
	endtask

	// Random phases on small tori so that generations stay cheap; one phase
	// is a wide strip. Coordinates mostly land in or just past the window,
	// the rest span the whole field. Cells outside a shrunken window must
	// survive until it grows again.
	task automatic test_random_traffic();
		int unsigned pick;
		logic [CoordW-1:0] x, y;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 3) begin
				write_size(CFG_WIDTH, 7'd127);
				write_size(CFG_HEIGHT, 7'd3);
			end else begin
				write_size(CFG_WIDTH, 7'($urandom_range(0, 10)));
				write_size(CFG_HEIGHT, 7'($urandom_range(0, 10)));
			end
			for (int n = 0; n < 19; n++) begin
				if (phase == 2 && n == 10) wait_drained();
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					x = 6'($urandom_range(0, active_cols()));
					y = 6'($urandom_range(0, active_rows()));
				end else begin
					x = 6'($urandom_range(0, 63));
					y = 6'($urandom_range(0, 63));
				end
				pick = $urandom_range(0, 99);
				if (pick < 45)
					send_command(KIND_WRITE, x, y, $urandom_range(0, 99) < 60,
						$urandom_range(0, 99) < 20);
				else if (pick < 75)
					send_command(KIND_READ, x, y, 1'($urandom), 1'($urandom));
				else if (pick < 92)
					send_command(KIND_GEN, x, y, 1'($urandom), 1'($urandom));
				else
					send_command(KIND_NOP, x, y, 1'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_READ;
		cell_x = '0;
		cell_y = '0;
		alive_in = 1'b0;
		obstacle_in = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		width_reg = 7'd64;
		height_reg = 7'd64;
		mismatches = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_cell_access();
		test_size_extremes();
		test_glider_full_size();
		test_random_traffic();

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

>>> files.f
rtl/core/tlge_pkg.sv
rtl/core/toroidal_life_generation_engine.sv
rtl/core/tlge_checker.sv
sim/tb_top.sv
